// File: rtl/apf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package apf_pkg;

    // data widths
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    localparam int FRAC_BITS = 12;
    localparam int ACC_W     = 35;
    localparam int MAG_W     = ACC_W - 1;
    localparam int MAX_ORDER = 6;
    localparam int ORDER_W   = 3;

    // configuration port
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEAD     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FB_FIRST = 3'd2;

    // register values after reset
    localparam logic [ORDER_W-1:0]       ORDER_RESET = '0;
    localparam logic signed [COEF_W-1:0] LEAD_RESET  = 16'sd4096;

    // serial divider: quotient bits produced one per cycle
    localparam int QUO_W     = SAMPLE_W + 1;
    localparam int DIV_STEPS = QUO_W;
    localparam int DIV_CNT_W = 5;

    // saturation limits on the quotient magnitude
    localparam logic [QUO_W-1:0] POS_LIM = 17'd32767;
    localparam logic [QUO_W-1:0] NEG_LIM = 17'd32768;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

    // per-cell control
    typedef struct packed {
        logic clear;
        logic shift;
        logic coef_we;
        logic tap_en;
    } cell_ctl_t;

endpackage

`default_nettype wire

// File: rtl/apf_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module apf_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire apf_pkg::cell_ctl_t ctl,
    input  wire apf_pkg::coef_t     coef_data,
    input  wire apf_pkg::sample_t   hist_in,
    output apf_pkg::sample_t        hist_out,
    input  wire apf_pkg::acc_t      acc_in,
    output apf_pkg::acc_t           acc_out
);
    import apf_pkg::*;

    coef_t   coef_reg;
    sample_t hist_reg;
    prod_t   prod_reg;
    acc_t    acc_reg;
    acc_t    acc_next;

    // coefficient and one history entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
            hist_reg <= '0;
        end
        else
        begin
            if (ctl.coef_we)
            begin
                coef_reg <= coef_data;
            end
            if (ctl.clear)
            begin
                hist_reg <= '0;
            end
            else if (ctl.shift)
            begin
                hist_reg <= hist_in;
            end
        end
    end

    // partial sum handed on to the next cell
    always_comb
    begin
        acc_next = acc_in;
        if (ctl.tap_en)
        begin
            acc_next = acc_in - ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= coef_reg * hist_reg;
        acc_reg  <= acc_next;
    end

    assign hist_out = hist_reg;
    assign acc_out  = acc_reg;

endmodule

`default_nettype wire

// File: rtl/apf_div.sv
`timescale 1ns / 1ps
`default_nettype none

module apf_div (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire apf_pkg::acc_t    num,
    input  wire apf_pkg::coef_t   den,
    output apf_pkg::sample_t      result,
    output logic                  sat,
    output logic                  done
);
    import apf_pkg::*;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_LOAD,
        DV_ITER,
        DV_DONE
    } dv_state_t;

    dv_state_t             state_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    sample_t               result_reg;
    logic                  sat_reg;
    logic                  done_reg;

    logic                  neg_reg;
    logic [MAG_W-1:0]      mag_reg;
    logic [COEF_W-1:0]     dmag_reg;
    logic                  ovf_reg;
    logic [QUO_W-1:0]      rem_reg;
    logic [QUO_W-1:0]      low_reg;

    acc_t                  num_abs;
    logic [COEF_W:0]       den_ext;
    logic [COEF_W:0]       den_abs;
    logic [QUO_W-1:0]      dsor;
    logic [ACC_W-1:0]      dvd;
    logic [QUO_W:0]        trial;
    logic [QUO_W:0]        trial_diff;
    logic                  trial_ge;
    logic [QUO_W-1:0]      quo_neg;
    logic                  pos_sat;
    logic                  neg_sat;
    sample_t               result_next;

    // magnitudes of the operands
    always_comb
    begin
        num_abs = num[ACC_W-1] ? -num : num;
        den_ext = {den[COEF_W-1], den};
        den_abs = den[COEF_W-1] ? (~den_ext + 1'b1) : den_ext;
    end

    // rounding dividend 2|n| + |d| over divisor 2|d|
    always_comb
    begin
        dsor = {dmag_reg, 1'b0};
        dvd  = {mag_reg, 1'b0} + ACC_W'(dmag_reg);
    end

    // one restoring step
    always_comb
    begin
        trial      = {rem_reg, low_reg[QUO_W-1]};
        trial_ge   = trial >= {1'b0, dsor};
        trial_diff = trial - {1'b0, dsor};
    end

    // sign and saturation of the quotient
    always_comb
    begin
        quo_neg = ~low_reg + 1'b1;
        pos_sat = !neg_reg && (ovf_reg || (low_reg > POS_LIM));
        neg_sat = neg_reg && (ovf_reg || (low_reg > NEG_LIM));
        if (pos_sat)
        begin
            result_next = SAMPLE_MAX;
        end
        else if (neg_sat)
        begin
            result_next = SAMPLE_MIN;
        end
        else if (neg_reg)
        begin
            result_next = quo_neg[SAMPLE_W-1:0];
        end
        else
        begin
            result_next = low_reg[SAMPLE_W-1:0];
        end
    end

    // sequencer and registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= DV_IDLE;
            cnt_reg    <= '0;
            result_reg <= '0;
            sat_reg    <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == DV_DONE);
            unique case (state_reg)
                DV_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= DV_LOAD;
                    end
                end
                DV_LOAD:
                begin
                    cnt_reg   <= '0;
                    state_reg <= DV_ITER;
                end
                DV_ITER:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                    begin
                        state_reg <= DV_DONE;
                    end
                end
                DV_DONE:
                begin
                    result_reg <= result_next;
                    sat_reg    <= pos_sat || neg_sat;
                    state_reg  <= DV_IDLE;
                end
                default:
                begin
                    state_reg <= DV_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == DV_IDLE && start)
        begin
            neg_reg  <= num[ACC_W-1] ^ den[COEF_W-1];
            mag_reg  <= num_abs[MAG_W-1:0];
            dmag_reg <= den_abs[COEF_W-1:0];
        end
        if (state_reg == DV_LOAD)
        begin
            ovf_reg <= dvd >= ACC_W'({dsor, {QUO_W{1'b0}}});
            rem_reg <= dvd[2*QUO_W-1:QUO_W];
            low_reg <= dvd[QUO_W-1:0];
        end
        if (state_reg == DV_ITER)
        begin
            rem_reg <= trial_ge ? trial_diff[QUO_W-1:0] : trial[QUO_W-1:0];
            low_reg <= {low_reg[QUO_W-2:0], trial_ge};
        end
    end

    assign result = result_reg;
    assign sat    = sat_reg;
    assign done   = done_reg;

endmodule

`default_nettype wire

// File: rtl/all_pole_iir_filter.sv
// each input runs through the tap-chain sum and the divider into the output register
// a new input is taken only after the previous result has been written to the output register
// the divider is a 17-step serial divider producing one quotient bit per step
// reset: asynchronous, active low; history cleared, order 0, a0 = 1.0, a1..a6 = 0
`timescale 1ns / 1ps
`default_nettype none

module all_pole_iir_filter (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [15:0]                       s_tdata,   // [15:0] sample_in
    input  wire logic                              s_tuser,   // [0] first_of_vector
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [15:0]                            m_tdata,   // [15:0] sample_out
    output logic                                   m_tuser,   // [0] saturated
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [apf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [apf_pkg::COEF_W-1:0]        cfg_data
);
    import apf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIVIDE,
        ST_WRITE
    } state_t;

    localparam logic [ORDER_W-1:0] SUM_LAST = ORDER_W'(MAX_ORDER + 1);

    state_t               state_reg;
    logic [ORDER_W-1:0]   cnt_reg;
    sample_t              x_reg;
    logic                 m_tvalid_reg;
    sample_t              m_tdata_reg;
    logic                 m_tuser_reg;

    logic [ORDER_W-1:0]   order_reg;
    coef_t                lead_reg;

    logic                 accept;
    logic                 cfg_we;
    logic                 out_free;
    logic                 wb;
    logic                 a0_zero;
    logic                 div_start;
    sample_t              div_y;
    logic                 div_sat;
    logic                 div_done;
    sample_t              y_wb;
    logic                 sat_wb;

    cell_ctl_t            cell_ctl [MAX_ORDER];
    sample_t              hist_link [MAX_ORDER+1];
    acc_t                 acc_link [MAX_ORDER+1];

    // handshakes
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign wb        = (state_reg == ST_WRITE) && out_free;
    assign div_start = (state_reg == ST_SUM) && (cnt_reg == SUM_LAST);

    // a zero leading coefficient overrides the divider
    assign a0_zero = (lead_reg == '0);
    assign y_wb    = a0_zero ? '0 : div_y;
    assign sat_wb  = a0_zero || div_sat;

    // configuration registers held outside the cells
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= ORDER_RESET;
            lead_reg  <= LEAD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ORDER: order_reg <= cfg_data[ORDER_W-1:0];
                REG_LEAD:  lead_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            x_reg        <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= 1'b0;
        end
        else
        begin
            if (m_tready && !wb)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        x_reg     <= s_tdata;
                        cnt_reg   <= '0;
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == SUM_LAST)
                    begin
                        state_reg <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_WRITE;
                    end
                end
                ST_WRITE:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= y_wb;
                        m_tuser_reg  <= sat_wb;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // head of the chain: x scaled to Q.12, newest output entering the history
    assign acc_link[0]  = {{(ACC_W-SAMPLE_W-FRAC_BITS){x_reg[SAMPLE_W-1]}}, x_reg,
                           {FRAC_BITS{1'b0}}};
    assign hist_link[0] = y_wb;

    // row of tap cells
    for (genvar g = 0; g < MAX_ORDER; g++)
    begin : g_cell
        assign cell_ctl[g].clear   = accept && s_tuser;
        assign cell_ctl[g].shift   = wb;
        assign cell_ctl[g].coef_we = cfg_we && (cfg_index == REG_FB_FIRST + CFG_IDX_W'(g));
        assign cell_ctl[g].tap_en  = (order_reg >= ORDER_W'(g + 1));

        apf_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (cell_ctl[g]),
            .coef_data (cfg_data),
            .hist_in   (hist_link[g]),
            .hist_out  (hist_link[g+1]),
            .acc_in    (acc_link[g]),
            .acc_out   (acc_link[g+1])
        );
    end

    // rounding divider by a0
    apf_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (acc_link[MAX_ORDER]),
        .den    (lead_reg),
        .result (div_y),
        .sat    (div_sat),
        .done   (div_done)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // checks
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIVIDE))
        else $error("divider finished outside the divide phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("input taken while an item is in work");

    assert property (@(posedge clk) disable iff (!rst_n)
        (wb && a0_zero) |=> (m_tuser && (m_tdata == '0)))
        else $error("zero leading coefficient not flagged");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (state_reg == ST_SUM) && !m_tvalid_reg || (state_reg == ST_SUM))
        else $error("divider started outside the sum phase");

endmodule

`default_nettype wire
